@@ rtl/srld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_pkg: shared types and constants of the sprite RLE line decoder
// Field widths, the coordinate width and the result beat structure.
// ----------------------------------------------------------------------------
package srld_pkg;

  localparam int COORD_BITS = 16;
  localparam int WORD_W     = 16;
  localparam int RUN_XY_W   = 16;
  localparam int LEN_W      = 7;
  localparam int COUNT_W    = 15;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register index decoded from the word address
  localparam logic REG_BIG_ENDIAN = 1'b0;

  // Result kinds
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [WORD_W-1:0]     word_t;

  typedef struct packed {
    logic                result_kind;
    logic [RUN_XY_W-1:0] run_x;
    logic [RUN_XY_W-1:0] run_y;
    logic [LEN_W-1:0]    run_length;
    logic [7:0]          pixel_value;
    logic                last;
  } result_t;

endpackage

@@ rtl/srld_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_ifs: stream channel interfaces
// Byte input channel and run result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       start_of_image;

  modport source (output valid, output stream_byte, output start_of_image, input ready);
  modport sink   (input valid, input stream_byte, input start_of_image, output ready);
endinterface

interface srld_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [srld_pkg::RUN_XY_W-1:0] run_x;
  logic [srld_pkg::RUN_XY_W-1:0] run_y;
  logic [srld_pkg::LEN_W-1:0]    run_length;
  logic [7:0]                    pixel_value;
  logic                          last;

  modport source (output valid, output result_kind, output run_x, output run_y,
                  output run_length, output pixel_value, output last, input ready);
  modport sink   (input valid, input result_kind, input run_x, input run_y,
                  input run_length, input pixel_value, input last, output ready);
endinterface

@@ rtl/srld_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_cfg_regs: APB configuration register
// Holds the word byte-order select.
// ----------------------------------------------------------------------------
module srld_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srld_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [srld_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [srld_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic                             big_endian
);
  import srld_pkg::*;

  logic big_endian_r;
  logic big_endian_nxt;
  logic reg_hit;

  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_BIG_ENDIAN);
  assign pready  = 1'b1;

  always_comb begin
    big_endian_nxt = big_endian_r;
    if (psel && penable && pwrite && reg_hit) begin
      big_endian_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else begin
      big_endian_r <= big_endian_nxt;
    end
  end

  assign prdata     = reg_hit ? {{(CFG_DATA_W-1){1'b0}}, big_endian_r} : '0;
  assign big_endian = big_endian_r;

endmodule

@@ rtl/srld_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_parser: stream parser state and run generation
// Consumes one byte per accepted beat and emits at most one result.
// ----------------------------------------------------------------------------
module srld_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              big_endian,
  input  logic              byte_fire,
  input  logic [7:0]        stream_byte,
  input  logic              start_of_image,
  output logic              res_valid,
  output srld_pkg::result_t res
);
  import srld_pkg::*;

  localparam logic [3:0] PH_HDR_A    = 4'd0;
  localparam logic [3:0] PH_HDR_B    = 4'd1;
  localparam logic [3:0] PH_KEY_A    = 4'd2;
  localparam logic [3:0] PH_KEY_B    = 4'd3;
  localparam logic [3:0] PH_VX_A     = 4'd4;
  localparam logic [3:0] PH_VX_B     = 4'd5;
  localparam logic [3:0] PH_VY_A     = 4'd6;
  localparam logic [3:0] PH_VY_B     = 4'd7;
  localparam logic [3:0] PH_LIT      = 4'd8;
  localparam logic [3:0] PH_PKT_HEAD = 4'd9;
  localparam logic [3:0] PH_PKT_LIT  = 4'd10;
  localparam logic [3:0] PH_PKT_REP  = 4'd11;
  localparam logic [3:0] PH_DONE     = 4'd12;

  logic [3:0]         phase_r, phase_nxt, phase_c;
  logic [7:0]         hold_r, hold_nxt, hold_c;
  coord_t             orig_x_r, orig_x_nxt, orig_x_c;
  coord_t             orig_y_r, orig_y_nxt, orig_y_c;
  word_t              key_r, key_nxt, key_c;
  coord_t             cur_x_r, cur_x_nxt, cur_x_c;
  coord_t             cur_y_r, cur_y_nxt, cur_y_c;
  logic [COUNT_W-1:0] done_r, done_nxt, done_c;
  logic [LEN_W-1:0]   rem_r, rem_nxt, rem_c;
  logic               rep_r, rep_nxt, rep_c;

  word_t              word_v;
  logic [LEN_W-1:0]   add_n;
  logic [COUNT_W:0]   done_sum;
  logic [COUNT_W-1:0] done_sat;
  logic               line_full;
  logic [LEN_W-1:0]   rem_inc;
  logic [LEN_W-1:0]   rem_dec;

  // Start mark clears the parser before this byte is parsed
  always_comb begin
    if (start_of_image) begin
      phase_c  = PH_HDR_A;
      hold_c   = '0;
      orig_x_c = '0;
      orig_y_c = '0;
      key_c    = '0;
      cur_x_c  = '0;
      cur_y_c  = '0;
      done_c   = '0;
      rem_c    = '0;
      rep_c    = 1'b0;
    end else begin
      phase_c  = phase_r;
      hold_c   = hold_r;
      orig_x_c = orig_x_r;
      orig_y_c = orig_y_r;
      key_c    = key_r;
      cur_x_c  = cur_x_r;
      cur_y_c  = cur_y_r;
      done_c   = done_r;
      rem_c    = rem_r;
      rep_c    = rep_r;
    end
  end

  assign word_v = big_endian ? {hold_c, stream_byte} : {stream_byte, hold_c};

  // Pixels added by this byte: one for a literal, the run length for a repeat
  assign add_n     = (phase_c == PH_PKT_REP) ? rem_c : LEN_W'(1);
  assign done_sum  = {1'b0, done_c} + (COUNT_W+1)'(add_n);
  assign done_sat  = done_sum[COUNT_W] ? {COUNT_W{1'b1}} : done_sum[COUNT_W-1:0];
  assign line_full = (done_sat >= key_c[WORD_W-1:1]);
  assign rem_inc   = rem_c + LEN_W'(1);
  assign rem_dec   = rem_c - LEN_W'(1);

  always_comb begin
    phase_nxt  = phase_c;
    hold_nxt   = hold_c;
    orig_x_nxt = orig_x_c;
    orig_y_nxt = orig_y_c;
    key_nxt    = key_c;
    cur_x_nxt  = cur_x_c;
    cur_y_nxt  = cur_y_c;
    done_nxt   = done_c;
    rem_nxt    = rem_c;
    rep_nxt    = rep_c;
    res_valid  = 1'b0;
    res        = '0;
    res.result_kind = KIND_RUN;
    res.run_x       = RUN_XY_W'(cur_x_c);
    res.run_y       = RUN_XY_W'(cur_y_c);
    res.run_length  = LEN_W'(1);
    res.pixel_value = stream_byte;

    case (phase_c)
      PH_HDR_A, PH_KEY_A, PH_VX_A, PH_VY_A: begin
        hold_nxt  = stream_byte;
        phase_nxt = phase_c + 4'd1;
      end
      PH_HDR_B: begin
        // Header words: x2, x1, y1, y2; keep x1 and y1 as the origin
        if (rem_c == LEN_W'(1)) begin
          orig_x_nxt = coord_t'(word_v);
        end else if (rem_c == LEN_W'(2)) begin
          orig_y_nxt = coord_t'(word_v);
        end
        if (rem_inc >= LEN_W'(4)) begin
          rem_nxt   = '0;
          phase_nxt = PH_KEY_A;
        end else begin
          rem_nxt   = rem_inc;
          phase_nxt = PH_HDR_A;
        end
      end
      PH_KEY_B: begin
        key_nxt   = word_v;
        phase_nxt = PH_VX_A;
      end
      PH_VX_B: begin
        cur_x_nxt = orig_x_c + coord_t'(word_v);
        phase_nxt = PH_VY_A;
      end
      PH_VY_B: begin
        cur_y_nxt = orig_y_c + coord_t'(word_v);
        done_nxt  = '0;
        if (key_c == '0) begin
          phase_nxt       = PH_DONE;
          res_valid       = 1'b1;
          res             = '0;
          res.result_kind = KIND_END;
          res.last        = 1'b1;
        end else if (!key_c[0]) begin
          phase_nxt = PH_LIT;
        end else if (key_c[WORD_W-1:1] == '0) begin
          phase_nxt = PH_KEY_A;
        end else begin
          phase_nxt = PH_PKT_HEAD;
        end
      end
      PH_LIT: begin
        res_valid = 1'b1;
        cur_x_nxt = cur_x_c + coord_t'(1);
        done_nxt  = done_sat;
        if (line_full) begin
          phase_nxt = PH_KEY_A;
        end
      end
      PH_PKT_HEAD: begin
        rem_nxt = stream_byte[7:1];
        rep_nxt = stream_byte[0];
        if (stream_byte[0]) begin
          phase_nxt = PH_PKT_REP;
        end else if (stream_byte[7:1] == '0) begin
          phase_nxt = PH_PKT_HEAD;
        end else begin
          phase_nxt = PH_PKT_LIT;
        end
      end
      PH_PKT_LIT: begin
        res_valid = 1'b1;
        cur_x_nxt = cur_x_c + coord_t'(1);
        done_nxt  = done_sat;
        rem_nxt   = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = line_full ? PH_KEY_A : PH_PKT_HEAD;
        end
      end
      PH_PKT_REP: begin
        rem_nxt   = '0;
        phase_nxt = PH_PKT_HEAD;
        if (rem_c != '0) begin
          res_valid      = 1'b1;
          res.run_length = rem_c;
          cur_x_nxt      = cur_x_c + coord_t'(rem_c);
          done_nxt       = done_sat;
          phase_nxt      = line_full ? PH_KEY_A : PH_PKT_HEAD;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (!byte_fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR_A;
      hold_r   <= '0;
      orig_x_r <= '0;
      orig_y_r <= '0;
      key_r    <= '0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      done_r   <= '0;
      rem_r    <= '0;
      rep_r    <= 1'b0;
    end else if (byte_fire) begin
      phase_r  <= phase_nxt;
      hold_r   <= hold_nxt;
      orig_x_r <= orig_x_nxt;
      orig_y_r <= orig_y_nxt;
      key_r    <= key_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      done_r   <= done_nxt;
      rem_r    <= rem_nxt;
      rep_r    <= rep_nxt;
    end
  end

endmodule

@@ rtl/srld_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_out_buf: two-entry result register with skid slot
// Decouples the parser from output backpressure.
// ----------------------------------------------------------------------------
module srld_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srld_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output srld_pkg::result_t out_data
);
  import srld_pkg::*;

  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  logic    pop;

  assign pop = head_vld_r && out_ready;

  always_comb begin
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    // Advance the skid slot into the head on a taken beat
    if (pop) begin
      head_nxt     = skid_r;
      head_vld_nxt = skid_vld_r;
      skid_vld_nxt = 1'b0;
    end
    if (push) begin
      if (!head_vld_nxt) begin
        head_nxt     = push_data;
        head_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = head_vld_r && skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

endmodule

@@ rtl/sprite_rle_line_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_rle_line_decoder_core: run-length sprite byte stream decoder
// Parses header, line keys and packets one byte per beat; emits pixel runs
// and an end-of-image beat.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  in_beat   sink       valid/ready          stream_byte, start_of_image
//  out_beat  source     valid/ready          result_kind, run_x, run_y,
//                                            run_length, pixel_value, last
//  APB       slave      psel/penable/pready  big_endian_words at address 0
//
//  One byte is accepted per cycle unless the buffer is full; its result, if
//  any, is registered in the output buffer ahead of out_beat. Throughput is
//  one beat per clock while a buffer entry is free, set by the combinational
//  parser update. A two-entry buffer keeps input flowing while one result
//  waits; in_beat.ready drops only when both are held. Synchronous active-low
//  reset clears the parser, the buffer and the configuration register.
//
module sprite_rle_line_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  srld_in_if.sink                         in_beat,
  srld_out_if.source                      out_beat,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srld_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [srld_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [srld_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import srld_pkg::*;

  logic    big_endian;
  logic    buf_full;
  logic    byte_fire;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // Configuration register: to be written only while the stream is idle; the block does not enforce it
  srld_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .big_endian (big_endian)
  );

  // Take a byte whenever the output buffer has a free entry
  assign in_beat.ready = !buf_full;
  assign byte_fire     = in_beat.valid && !buf_full;

  srld_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .big_endian     (big_endian),
    .byte_fire      (byte_fire),
    .stream_byte    (in_beat.stream_byte),
    .start_of_image (in_beat.start_of_image),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Hold results until the downstream side takes them
  srld_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_beat.valid),
    .out_ready (out_beat.ready),
    .out_data  (out_data)
  );

  assign out_beat.result_kind = out_data.result_kind;
  assign out_beat.run_x       = out_data.run_x;
  assign out_beat.run_y       = out_data.run_y;
  assign out_beat.run_length  = out_data.run_length;
  assign out_beat.pixel_value = out_data.pixel_value;
  assign out_beat.last        = out_data.last;

endmodule

@@ verif/sprite_rle_line_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_rle_line_decoder_core_tb: self-checking bench for the sprite decoder
// Feeds encoded sprite byte streams in both word orders, predicts every run
// and end-of-image beat in step with the input, and checks each output beat
// field by field under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module sprite_rle_line_decoder_core_tb;
  import srld_pkg::*;

  // Parser phases of the predictor, one per kind of byte the stream can hold
  localparam logic [3:0] ST_HDR_0    = 4'd0;
  localparam logic [3:0] ST_HDR_1    = 4'd1;
  localparam logic [3:0] ST_KEY_0    = 4'd2;
  localparam logic [3:0] ST_KEY_1    = 4'd3;
  localparam logic [3:0] ST_VX_0     = 4'd4;
  localparam logic [3:0] ST_VX_1     = 4'd5;
  localparam logic [3:0] ST_VY_0     = 4'd6;
  localparam logic [3:0] ST_VY_1     = 4'd7;
  localparam logic [3:0] ST_LITERAL  = 4'd8;
  localparam logic [3:0] ST_PKT_HEAD = 4'd9;
  localparam logic [3:0] ST_PKT_LIT  = 4'd10;
  localparam logic [3:0] ST_PKT_REP  = 4'd11;
  localparam logic [3:0] ST_DONE     = 4'd12;

  localparam int COUNT_SAT    = 32767;
  localparam int TIMEOUT_NS   = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int SAT_PACKETS  = 259;   // 259 * 127 pixels crosses the count ceiling

  localparam logic [CFG_ADDR_W-1:0] ADDR_BIG_ENDIAN = CFG_ADDR_W'(4 * REG_BIG_ENDIAN);
  localparam logic [CFG_DATA_W-1:0] ORDER_LITTLE    = '0;
  localparam logic [CFG_DATA_W-1:0] ORDER_BIG       = CFG_DATA_W'(1);

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  srld_in_if  in_ch ();
  srld_out_if out_ch ();

  sprite_rle_line_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the parser and of the word-order bit
  // --------------------------------------------------------------------------
  logic               big_endian_cfg;
  logic [3:0]         st;
  logic [7:0]         held_byte;
  coord_t             org_x;
  coord_t             org_y;
  word_t              key_word;
  coord_t             cur_x;
  coord_t             cur_y;
  logic [COUNT_W-1:0] px_done;
  logic [LEN_W-1:0]   pkt_left;
  logic               pkt_rep;

  result_t    expected_runs[$];
  logic [7:0] image_bytes[$];

  int  error_count     = 0;
  int  items_sent      = 0;
  int  results_seen    = 0;
  int  hold_off_cycles = 0;
  bit  quiet_sender    = 0;
  bit  steady_sink     = 0;

  // Assemble a 16-bit word from the held byte and the one just arrived
  function automatic word_t join_word(input logic [7:0] second);
    return big_endian_cfg ? {held_byte, second} : {second, held_byte};
  endfunction

  // A line is over once its pixel count has reached key/2
  function automatic logic line_full();
    return px_done >= key_word[WORD_W-1:1];
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic clear_parser();
    st        = ST_HDR_0;
    held_byte = '0;
    org_x     = '0;
    org_y     = '0;
    key_word  = '0;
    cur_x     = '0;
    cur_y     = '0;
    px_done   = '0;
    pkt_left  = '0;
    pkt_rep   = 1'b0;
  endtask

  task automatic count_pixels(input int n);
    int sum;
    sum = int'(px_done) + n;
    px_done = (sum > COUNT_SAT) ? COUNT_W'(COUNT_SAT) : COUNT_W'(sum);
  endtask

  task automatic push_result(input logic kind, input coord_t x, input coord_t y,
                             input logic [LEN_W-1:0] len, input logic [7:0] val,
                             input logic fin);
    result_t r;
    r.result_kind = kind;
    r.run_x       = x;
    r.run_y       = y;
    r.run_length  = len;
    r.pixel_value = val;
    r.last        = fin;
    expected_runs.push_back(r);
  endtask

  // Advance the predictor by one accepted byte; queue the beat it causes, if any
  task automatic decode_byte(input logic [7:0] b, input logic sop);
    word_t w;
    int    n;
    if (sop) clear_parser();
    case (st)
      ST_HDR_0, ST_KEY_0, ST_VX_0, ST_VY_0: begin
        held_byte = b;
        st = st + 4'd1;
      end
      ST_HDR_1: begin
        // pkt_left doubles as the header word index: x2, x1, y1, y2
        w = join_word(b);
        if (pkt_left == LEN_W'(1)) org_x = w;
        else if (pkt_left == LEN_W'(2)) org_y = w;
        pkt_left = pkt_left + LEN_W'(1);
        if (pkt_left >= LEN_W'(4)) begin
          st = ST_KEY_0;
          pkt_left = '0;
        end else begin
          st = ST_HDR_0;
        end
      end
      ST_KEY_1: begin
        key_word = join_word(b);
        st = ST_VX_0;
      end
      ST_VX_1: begin
        cur_x = org_x + join_word(b);
        st = ST_VY_0;
      end
      ST_VY_1: begin
        cur_y = org_y + join_word(b);
        px_done = '0;
        if (key_word == '0) begin
          st = ST_DONE;
          push_result(KIND_END, '0, '0, '0, '0, 1'b1);
        end else if (!key_word[0]) begin
          st = ST_LITERAL;
        end else begin
          st = line_full() ? ST_KEY_0 : ST_PKT_HEAD;
        end
      end
      ST_LITERAL: begin
        push_result(KIND_RUN, cur_x, cur_y, LEN_W'(1), b, 1'b0);
        cur_x = cur_x + coord_t'(1);
        count_pixels(1);
        if (line_full()) st = ST_KEY_0;
      end
      ST_PKT_HEAD: begin
        pkt_left = b[7:1];
        pkt_rep  = b[0];
        if (pkt_rep) st = ST_PKT_REP;
        else if (pkt_left == '0) st = ST_PKT_HEAD;
        else st = ST_PKT_LIT;
      end
      ST_PKT_LIT: begin
        push_result(KIND_RUN, cur_x, cur_y, LEN_W'(1), b, 1'b0);
        cur_x = cur_x + coord_t'(1);
        count_pixels(1);
        pkt_left = pkt_left - LEN_W'(1);
        if (pkt_left == '0) st = line_full() ? ST_KEY_0 : ST_PKT_HEAD;
      end
      ST_PKT_REP: begin
        // A repeat of zero swallows its value byte without a beat
        n = int'(pkt_left);
        pkt_left = '0;
        st = ST_PKT_HEAD;
        if (n != 0) begin
          push_result(KIND_RUN, cur_x, cur_y, LEN_W'(n), b, 1'b0);
          cur_x = cur_x + coord_t'(n);
          count_pixels(n);
          st = line_full() ? ST_KEY_0 : ST_PKT_HEAD;
        end
      end
      default: st = ST_DONE;   // image over: drop bytes until the next start mark
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stream building, in the word order currently programmed
  // --------------------------------------------------------------------------
  task automatic add_word(input word_t w);
    if (big_endian_cfg) begin
      image_bytes.push_back(w[15:8]);
      image_bytes.push_back(w[7:0]);
    end else begin
      image_bytes.push_back(w[7:0]);
      image_bytes.push_back(w[15:8]);
    end
  endtask

  task automatic add_line_head(input word_t key);
    add_word(key);
    add_word(rand_word());
    add_word(rand_word());
  endtask

  task automatic add_header();
    image_bytes.delete();
    repeat (4) add_word(rand_word());   // x2, x1, y1, y2
  endtask

  // Well-formed image: header, zero to four short lines of random kinds, end line
  task automatic build_image();
    int lines;
    int n;
    int k;
    int got;
    add_header();
    lines = $urandom_range(0, 4);
    repeat (lines) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 6);
          add_line_head(word_t'(2 * n));
          repeat (n) image_bytes.push_back(8'($urandom));
        end
        4: add_line_head(word_t'(1));
        default: begin
          n = $urandom_range(1, 10);
          add_line_head(word_t'(2 * n + 1));
          got = 0;
          // Packets run until the line is covered, the last may overshoot
          while (got < n) begin
            if ($urandom_range(0, 1)) begin
              k = $urandom_range(0, 4);
              image_bytes.push_back(8'(2 * k));
              repeat (k) image_bytes.push_back(8'($urandom));
            end else begin
              k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
              image_bytes.push_back(8'(2 * k + 1));
              image_bytes.push_back(8'($urandom));
            end
            got += k;
          end
        end
      endcase
    end
    add_line_head('0);
  endtask

  // --------------------------------------------------------------------------
  // Input channel driver
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic sop);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.stream_byte    <= b;
    in_ch.start_of_image <= sop;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, sop);
    items_sent++;
  endtask

  // Send the first len bytes of the built image; a short len truncates it
  task automatic send_image(input int len, input logic mark);
    for (int i = 0; i < len; i++) send_byte(image_bytes[i], mark && (i == 0));
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom), ($urandom_range(0, 9) == 0));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Hold the input until every queued beat is out, then let the buffer settle
  task automatic settle_block();
    idle_input();
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_BIG_ENDIAN) big_endian_cfg = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_word_order(input logic [CFG_DATA_W-1:0] order);
    settle_block();
    write_reg(ADDR_BIG_ENDIAN, order);
  endtask

  // --------------------------------------------------------------------------
  // Result channel: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink_driver
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady_sink) stall = pick_gap();
      end
    end
  end

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected result beat: kind %0d x %0h y %0h len %0d val %0h last %0d",
               out_ch.result_kind, out_ch.run_x, out_ch.run_y, out_ch.run_length,
               out_ch.pixel_value, out_ch.last);
        error_count++;
      end else begin
        want = expected_runs.pop_front();
        results_seen++;
        if (out_ch.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind, out_ch.result_kind);
          error_count++;
        end
        if (out_ch.run_x !== want.run_x) begin
          $error("run_x: expected %0h, actual %0h", want.run_x, out_ch.run_x);
          error_count++;
        end
        if (out_ch.run_y !== want.run_y) begin
          $error("run_y: expected %0h, actual %0h", want.run_y, out_ch.run_y);
          error_count++;
        end
        if (out_ch.run_length !== want.run_length) begin
          $error("run_length: expected %0d, actual %0d", want.run_length, out_ch.run_length);
          error_count++;
        end
        if (out_ch.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %0h, actual %0h", want.pixel_value, out_ch.pixel_value);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner image sent right after reset with no start mark: wrapping origin,
  // a key of one, zero-length literal and repeat packets, a single literal,
  // a full 127-pixel repeat that overruns the line, the end beat, and a byte
  // after the end that must be dropped.
  task automatic test_directed_corners();
    image_bytes.delete();
    add_word(16'h0000);
    add_word(16'hFFFF);        // origin x at the top of the range
    add_word(16'hFFFE);
    add_word(16'h1234);
    add_word(16'h0001);        // key of one: the line carries no packets
    add_word(16'h0002);
    add_word(16'h0003);
    add_word(16'h0007);        // three pixels by packets
    add_word(16'hFFFF);
    add_word(16'h0000);
    image_bytes.push_back(8'h00);   // empty literal packet
    image_bytes.push_back(8'h01);   // empty repeat: value byte, no beat
    image_bytes.push_back(8'hAA);
    image_bytes.push_back(8'h02);   // one literal pixel
    image_bytes.push_back(8'h00);
    image_bytes.push_back(8'hFF);   // repeat 127 times, past the line's end
    image_bytes.push_back(8'hFF);
    add_word(16'h0000);        // end of image
    add_word(16'h0000);
    add_word(16'h0000);
    image_bytes.push_back(8'h55);   // after the end: dropped
    send_image(image_bytes.size(), 1'b0);
  endtask

  // Mostly whole images with start marks; some cut short by the next image,
  // some plain noise with stray start marks.
  task automatic test_random_images(input int n_items);
    int goal;
    int r;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      // Now and then run an image or noise with neither side idling
      quiet_sender = ($urandom_range(0, 9) == 0);
      steady_sink  = quiet_sender;
      build_image();
      r = $urandom_range(0, 99);
      if (r < 80) send_image(image_bytes.size(), 1'b1);
      else if (r < 92) send_image($urandom_range(1, image_bytes.size()), 1'b1);
      else send_noise($urandom_range(1, 12));
    end
    quiet_sender = 0;
    steady_sink  = 0;
  endtask

  // One line long enough to drive the pixel count into its ceiling
  task automatic test_saturating_line();
    add_header();
    add_line_head(16'hFFFF);
    repeat (SAT_PACKETS) begin
      image_bytes.push_back(8'hFF);
      image_bytes.push_back(8'($urandom));
    end
    add_line_head('0);
    send_image(image_bytes.size(), 1'b1);
  endtask

  // Stop the sink for a long stretch while bytes keep coming, so the output
  // buffer fills and the input stalls
  task automatic test_output_hold_off();
    quiet_sender    = 1;
    hold_off_cycles = HOLD_CYCLES;
    while (hold_off_cycles > 0) begin
      build_image();
      send_image(image_bytes.size(), 1'b1);
    end
    quiet_sender = 0;
  endtask

  // Pause the sender mid-stream until every pending beat has drained
  task automatic test_drain_pause();
    test_random_images(100);
    settle_block();
    test_random_images(100);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.stream_byte    = '0;
    in_ch.start_of_image = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    big_endian_cfg       = 1'b0;
    clear_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    set_word_order(ORDER_BIG);
    test_random_images(300);
    test_saturating_line();
    set_word_order(ORDER_LITTLE);
    test_drain_pause();
    test_output_hold_off();
    set_word_order(ORDER_BIG);
    test_random_images(200);
    test_output_hold_off();
    set_word_order(ORDER_LITTLE);
    test_random_images(150);

    settle_block();
    $display("Covered %0d input beats and %0d result beats in both word orders,", items_sent,
             results_seen);
    $display("including empty and overrunning packets, a saturated line and output hold-offs.");
    if (error_count == 0) begin
      $display("** sprite_rle_line_decoder_core: PASSED **");
    end else begin
      $display("** sprite_rle_line_decoder_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("** sprite_rle_line_decoder_core: FAILED **");
    $finish;
  end

endmodule
